>>> sv/ucn_pkg.sv
package ucn_pkg;

   typedef enum logic [2:0] {
      MODE_SCHEME = 3'd0,
      MODE_REG_NAME = 3'd1,
      MODE_PORT = 3'd2,
      MODE_PATH = 3'd3,
      MODE_IPV4 = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_ILLEGAL = 2'd1,
      ST_RANGE = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_PCT = 2'd1,
      ESC_HEX1 = 2'd2
   } escape_type;

   localparam logic [7:0] CHAR_PCT = 8'h25;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [9:0] OCTET_MAX = 10'd255;
   localparam logic [9:0] OCTET_MIN3 = 10'd100;
   localparam logic [9:0] OCTET_MIN2 = 10'd10;
   localparam int GROUP_DEPTH = 3;

   // per-string parsing state
   typedef struct packed {
      escape_type escape_phase;
      logic [7:0] held_hex_digit;
      logic at_first_char;
      status_type error_code;
      logic [9:0] octet_value;
      logic [2:0] octet_digits;
      logic [2:0] dot_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      escape_phase: ESC_NONE,
      held_hex_digit: 8'd0,
      at_first_char: 1'b1,
      error_code: ST_OK,
      octet_value: 10'd0,
      octet_digits: 3'd0,
      dot_count: 3'd0
   };

   // results caused by one input item
   typedef struct packed {
      logic [GROUP_DEPTH-1:0][7:0] chars;
      logic [1:0] nchars;
      logic [1:0] total;
      logic done;
      status_type status;
   } group_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] to_upper(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   function automatic logic is_unres(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "-" || c == "." || c == "_" || c == "~";
   endfunction

   function automatic logic is_subdelim(input logic [7:0] c);
      return c == "!" || c == "$" || c == "&" || c == "'" || c == "(" || c == ")" ||
             c == "*" || c == "+" || c == "," || c == ";" || c == "=";
   endfunction

   function automatic status_type octet_check(input logic [2:0] digits,
                                              input logic [9:0] value);
      status_type r;
      r = ST_ILLEGAL;
      if (digits == 3'd1) begin
         r = ST_OK;
      end else if (digits == 3'd2) begin
         r = (value < OCTET_MIN2) ? ST_ILLEGAL : ST_OK;
      end else if (digits == 3'd3) begin
         r = (value < OCTET_MIN3 || value > OCTET_MAX) ? ST_ILLEGAL : ST_OK;
      end
      return r;
   endfunction

endpackage

>>> sv/ucn_step.sv
module ucn_step (
   input  ucn_pkg::mode_type   mode,
   input  ucn_pkg::state_type  state,
   input  logic [7:0]          char_code,
   input  logic                has_char,
   input  logic                end_of_string,
   output ucn_pkg::state_type  state_next,
   output ucn_pkg::group_type  group
);

   ucn_pkg::state_type st;
   ucn_pkg::status_type r;
   logic [2:0][7:0] em;
   logic [1:0] n;
   logic [7:0] c;

   assign c = char_code;

   always_comb begin
      st = state;
      r = ucn_pkg::ST_OK;
      em = '0;
      n = 2'd0;
      if (has_char) begin
         if (state.error_code == ucn_pkg::ST_OK) begin
            unique case (mode)
               ucn_pkg::MODE_SCHEME: begin
                  if (state.at_first_char && !ucn_pkg::is_alpha(c)) begin
                     r = ucn_pkg::ST_ILLEGAL;
                  end else if (!(ucn_pkg::is_alpha(c) || ucn_pkg::is_digit(c) ||
                                 c == "+" || c == "-" || c == ucn_pkg::CHAR_DOT)) begin
                     r = ucn_pkg::ST_ILLEGAL;
                  end else begin
                     em[0] = ucn_pkg::to_lower(c);
                     n = 2'd1;
                  end
               end
               ucn_pkg::MODE_REG_NAME, ucn_pkg::MODE_PATH: begin
                  if (state.escape_phase == ucn_pkg::ESC_PCT) begin
                     if (!ucn_pkg::is_hex(c)) begin
                        r = ucn_pkg::ST_ILLEGAL;
                     end else begin
                        st.held_hex_digit = ucn_pkg::to_upper(c);
                        st.escape_phase = ucn_pkg::ESC_HEX1;
                     end
                  end else if (state.escape_phase == ucn_pkg::ESC_HEX1) begin
                     if (!ucn_pkg::is_hex(c)) begin
                        r = ucn_pkg::ST_ILLEGAL;
                     end else begin
                        em[0] = ucn_pkg::CHAR_PCT;
                        em[1] = state.held_hex_digit;
                        em[2] = ucn_pkg::to_upper(c);
                        n = 2'd3;
                        st.escape_phase = ucn_pkg::ESC_NONE;
                        st.held_hex_digit = 8'd0;
                     end
                  end else if (c == ucn_pkg::CHAR_PCT) begin
                     st.escape_phase = ucn_pkg::ESC_PCT;
                  end else if (mode == ucn_pkg::MODE_REG_NAME) begin
                     if (!(ucn_pkg::is_unres(c) || ucn_pkg::is_subdelim(c))) begin
                        r = ucn_pkg::ST_ILLEGAL;
                     end else begin
                        em[0] = ucn_pkg::to_lower(c);
                        n = 2'd1;
                     end
                  end else begin
                     if (!(ucn_pkg::is_unres(c) || ucn_pkg::is_subdelim(c) ||
                           c == ucn_pkg::CHAR_COLON || c == ucn_pkg::CHAR_AT ||
                           c == ucn_pkg::CHAR_SLASH)) begin
                        r = ucn_pkg::ST_ILLEGAL;
                     end else begin
                        em[0] = c;
                        n = 2'd1;
                     end
                  end
               end
               ucn_pkg::MODE_PORT: begin
                  if (!ucn_pkg::is_digit(c)) begin
                     r = ucn_pkg::ST_ILLEGAL;
                  end else begin
                     em[0] = c;
                     n = 2'd1;
                  end
               end
               ucn_pkg::MODE_IPV4: begin
                  if (c == ucn_pkg::CHAR_DOT) begin
                     if (state.octet_digits == 3'd0) begin
                        r = ucn_pkg::ST_ILLEGAL;
                     end else if (state.dot_count >= 3'd4) begin
                        r = ucn_pkg::ST_RANGE;
                     end else begin
                        r = ucn_pkg::octet_check(state.octet_digits, state.octet_value);
                        if (r == ucn_pkg::ST_OK) begin
                           st.dot_count = state.dot_count + 3'd1;
                           st.octet_value = 10'd0;
                           st.octet_digits = 3'd0;
                           em[0] = c;
                           n = 2'd1;
                        end
                     end
                  end else if (state.octet_digits >= 3'd4) begin
                     r = ucn_pkg::ST_RANGE;
                  end else if (!ucn_pkg::is_digit(c)) begin
                     r = ucn_pkg::ST_ILLEGAL;
                  end else begin
                     if (state.octet_digits < 3'd3) begin
                        st.octet_value = 10'(state.octet_value * 4'd10) + 10'(c[3:0]);
                     end
                     st.octet_digits = state.octet_digits + 3'd1;
                     em[0] = c;
                     n = 2'd1;
                  end
               end
               default: begin
                  r = ucn_pkg::ST_ILLEGAL;
               end
            endcase
            if (r != ucn_pkg::ST_OK) begin
               st = state;
               st.error_code = r;
               em = '0;
               n = 2'd0;
            end
         end
         st.at_first_char = 1'b0;
      end

      group.chars = em;
      group.nchars = n;
      group.total = (end_of_string && n == 2'd0) ? 2'd1 : n;
      group.done = end_of_string;
      group.status = ucn_pkg::ST_OK;
      state_next = st;
      if (end_of_string) begin
         if (st.error_code != ucn_pkg::ST_OK) begin
            group.status = st.error_code;
         end else begin
            unique case (mode)
               ucn_pkg::MODE_REG_NAME, ucn_pkg::MODE_PATH: begin
                  group.status = (st.escape_phase != ucn_pkg::ESC_NONE) ?
                                 ucn_pkg::ST_ILLEGAL : ucn_pkg::ST_OK;
               end
               ucn_pkg::MODE_PORT: begin
                  group.status = ucn_pkg::ST_OK;
               end
               ucn_pkg::MODE_IPV4: begin
                  group.status = ucn_pkg::octet_check(st.octet_digits, st.octet_value);
                  if (group.status == ucn_pkg::ST_OK && st.dot_count != 3'd3) begin
                     group.status = ucn_pkg::ST_RANGE;
                  end
               end
               default: begin
                  group.status = st.at_first_char ? ucn_pkg::ST_EMPTY : ucn_pkg::ST_OK;
               end
            endcase
         end
         state_next = ucn_pkg::STATE_RESET;
      end
   end

endmodule

>>> sv/uri_component_normalizer.sv
// URI component normalizer.
// Characters of one component arrive on req_, one per item, with req_has_char
// and req_end_of_string; the item carrying end_of_string closes the string.
// The component kind comes from csr_component_mode, written with csr_wr_en;
// the user writes only while the block is idle (unchecked); a write restarts the string.
// Each input item gives zero to three rsp_ items: normalized characters, and
// for the closing item a verdict on rsp_status with rsp_string_done set.
// rsp_run_last marks the last rsp_ item caused by one input item.
// An item enters an input register, is parsed combinationally on its way
// into a result group register once that register is free, and its first
// result is offered from the result group register.
// One input item is taken per cycle while each gives at most one result and
// rsp_ready is high; a completed percent triplet takes three result items.
// The input register keeps taking an item while results wait on a stalled
// receiver; req_ready drops only when both registers are full.
// Reset (synchronous) empties both registers and sets the mode to scheme.
module uri_component_normalizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_code,
   input  logic       req_has_char,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_string_done,
   output logic [1:0] rsp_status,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_component_mode
);

   ucn_pkg::mode_type mode_ff, mode_in;
   ucn_pkg::state_type st_ff, st_in, st_next;
   ucn_pkg::group_type grp_ff, grp_in, grp_next;
   logic in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic in_has_ff;
   logic in_end_ff;
   logic grp_valid_ff, grp_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic req_fire, rsp_fire, grp_last, grp_free, move;

   ucn_step u_step (
      .mode          (mode_ff),
      .state         (st_ff),
      .char_code     (in_char_ff),
      .has_char      (in_has_ff),
      .end_of_string (in_end_ff),
      .state_next    (st_next),
      .group         (grp_next)
   );

   assign rsp_valid = grp_valid_ff;
   assign grp_last = idx_ff == grp_ff.total - 2'd1;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign grp_free = !grp_valid_ff || (rsp_fire && grp_last);
   assign move = in_valid_ff && (grp_next.total == 2'd0 || grp_free);
   assign req_ready = !in_valid_ff || move;
   assign req_fire = req_valid && req_ready;

   assign rsp_char_valid = idx_ff < grp_ff.nchars;
   assign rsp_out_char = rsp_char_valid ? grp_ff.chars[idx_ff] : 8'd0;
   assign rsp_run_last = grp_last;
   assign rsp_string_done = grp_ff.done && grp_last;
   assign rsp_status = rsp_string_done ? grp_ff.status : ucn_pkg::ST_OK;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end

      mode_in = mode_ff;
      st_in = st_ff;
      if (csr_wr_en) begin
         mode_in = ucn_pkg::mode_type'(csr_component_mode);
         st_in = ucn_pkg::STATE_RESET;
      end else if (move) begin
         st_in = st_next;
      end

      grp_valid_in = grp_valid_ff;
      idx_in = idx_ff;
      grp_in = grp_ff;
      if (move && grp_next.total != 2'd0) begin
         grp_valid_in = 1'b1;
         idx_in = 2'd0;
         grp_in = grp_next;
      end else if (rsp_fire) begin
         if (grp_last) begin
            grp_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         grp_valid_ff <= 1'b0;
         idx_ff <= 2'd0;
         mode_ff <= ucn_pkg::MODE_SCHEME;
         st_ff <= ucn_pkg::STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         grp_valid_ff <= grp_valid_in;
         idx_ff <= idx_in;
         mode_ff <= mode_in;
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_char_code;
         in_has_ff <= req_has_char;
         in_end_ff <= req_end_of_string;
      end
      grp_ff <= grp_in;
   end

   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (idx_ff < grp_ff.total))
      else $error("result index past end of group");

   a_empty_only_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> rsp_string_done)
      else $error("characterless result without verdict");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_string_done) |-> rsp_run_last)
      else $error("verdict not on last result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (grp_valid_ff && !(rsp_fire && grp_last)) |=> $stable(grp_ff))
      else $error("pending result group overwritten");

   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      (move && in_end_ff && !csr_wr_en) |=> (st_ff == ucn_pkg::STATE_RESET))
      else $error("state not cleared after end of string");

endmodule
